FILE: src/stq_pkg.sv
package stq_pkg;

  localparam int unsigned TIME_W = 63;
  localparam int unsigned ID_W   = 16;
  localparam int unsigned OP_W   = 2;

  localparam logic [TIME_W-1:0] EMPTY_TIMEOUT = 63'd1073741824000000;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  typedef enum logic [1:0] {
    EK_ZERO  = 2'd0,
    EK_FULL  = 2'd1,
    EK_FIRE  = 2'd2,
    EK_QUERY = 2'd3
  } emit_kind_e;

  typedef struct packed {
    logic       latch;
    logic       cmp;
    logic       ins;
    logic       pop;
    logic       emit;
    emit_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            due0;
    logic            due1;
    logic            out_free;
  } dp_stat_t;

endpackage

FILE: src/stq_ctrl.sv
module stq_ctrl
  import stq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;
  localparam logic [2:0] S_ADV  = 3'd5;

  logic [2:0] state_q, state_d;
  emit_kind_e kind_q, kind_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.kind = EK_ZERO;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        case (stat_i.op)
          OP_INSERT: begin
            if (stat_i.full) begin
              kind_d  = EK_FULL;
              state_d = S_EMIT;
            end else begin
              state_d = S_CMP;
            end
          end
          OP_ADVANCE: state_d = S_ADV;
          OP_QUERY: begin
            kind_d  = EK_QUERY;
            state_d = S_EMIT;
          end
          default: begin
            kind_d  = EK_ZERO;
            state_d = S_EMIT;
          end
        endcase
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_INS;
      end
      S_INS: begin
        cmd_o.ins = 1'b1;
        kind_d    = EK_ZERO;
        state_d   = S_EMIT;
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.kind = kind_q;
          state_d    = S_IDLE;
        end
      end
      S_ADV: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.due0) begin
            cmd_o.kind = EK_FIRE;
            cmd_o.pop  = 1'b1;
            if (!stat_i.due1) state_d = S_IDLE;
          end else begin
            cmd_o.kind = EK_ZERO;
            state_d    = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= EK_ZERO;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

endmodule

FILE: src/stq_dp.sv
module stq_dp
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [TIME_W-1:0] time_value_i,
  input  logic [ID_W-1:0]   task_id_i,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output logic              fired_valid_o,
  output logic [ID_W-1:0]   fired_id_o,
  output logic [TIME_W-1:0] timeout_o,
  output logic              status_o,
  output logic              last_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] t_q;
  logic [ID_W-1:0]   nid_q;

  logic [TIME_W-1:0] dl_q [DEPTH];
  logic [ID_W-1:0]   tid_q [DEPTH];
  logic [CW-1:0]     count_q;
  logic [DEPTH-1:0]  lt_q, lt_d;

  logic              out_valid_q;
  logic              fv_q, st_q, last_q;
  logic [ID_W-1:0]   fid_q;
  logic [TIME_W-1:0] tmo_q, tmo_d, diff;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= opcode_i;
      t_q   <= time_value_i;
      nid_q <= task_id_i;
    end
    if (cmd_i.cmp) lt_q <= lt_d;
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic              here;
    logic [TIME_W-1:0] prev_dl, next_dl;
    logic [ID_W-1:0]   prev_id, next_id;

    assign lt_d[g] = (CW'(g) < count_q) && (dl_q[g] < t_q);

    if (g == 0) begin : g_head
      assign here    = 1'b1;
      assign prev_dl = t_q;
      assign prev_id = nid_q;
    end else begin : g_body
      assign here    = lt_q[g-1];
      assign prev_dl = dl_q[g-1];
      assign prev_id = tid_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_dl = dl_q[g];
      assign next_id = tid_q[g];
    end else begin : g_mid
      assign next_dl = dl_q[g+1];
      assign next_id = tid_q[g+1];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.ins) begin
        if (!lt_q[g]) begin
          dl_q[g]  <= here ? t_q : prev_dl;
          tid_q[g] <= here ? nid_q : prev_id;
        end
      end else if (cmd_i.pop) begin
        dl_q[g]  <= next_dl;
        tid_q[g] <= next_id;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.ins) begin
      count_q <= count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_q <= count_q - CW'(1);
    end
  end

  assign stat_o.op       = op_q;
  assign stat_o.full     = (count_q == CW'(DEPTH));
  assign stat_o.due0     = (count_q != '0) && (dl_q[0] < t_q);
  assign stat_o.due1     = (count_q > CW'(1)) && (dl_q[1] < t_q);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  assign diff = dl_q[0] - t_q;

  always_comb begin
    if (count_q == '0) begin
      tmo_d = EMPTY_TIMEOUT;
    end else if (dl_q[0] > t_q) begin
      tmo_d = diff;
    end else begin
      tmo_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      fv_q   <= 1'b0;
      fid_q  <= '0;
      tmo_q  <= '0;
      st_q   <= 1'b0;
      last_q <= 1'b1;
      case (cmd_i.kind)
        EK_FULL:  st_q <= 1'b1;
        EK_QUERY: tmo_q <= tmo_d;
        EK_FIRE: begin
          fv_q   <= 1'b1;
          fid_q  <= tid_q[0];
          last_q <= !stat_o.due1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign fired_valid_o = fv_q;
  assign fired_id_o    = fid_q;
  assign timeout_o     = tmo_q;
  assign status_o      = st_q;
  assign last_o        = last_q;

endmodule

FILE: src/sorted_timer_queue.sv
// Channel | Handshake                | Beat
// in      | in_valid_i / in_stall_o  | opcode_i, time_value_i, task_id_i
// out     | out_valid_o / out_stall_i| fired_valid_o, fired_id_o, timeout_o, status_o, last_o
//
// One item at a time; a new item is taken once the previous one has loaded its last beat.
// Insert steps: accept, decode, parallel compare over all entries, shift, result.
// Query/full insert: accept, decode, result. Advance: a beat per due id, else an empty one.
// Reset empties the queue; entry contents are not cleared.
// out_stall_i holds the output register; the sequencer waits at its next beat, input stalled.
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   opcode_i,
  input  logic [TIME_W-1:0] time_value_i,
  input  logic [ID_W-1:0]   task_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              fired_valid_o,
  output logic [ID_W-1:0]   fired_id_o,
  output logic [TIME_W-1:0] timeout_o,
  output logic              status_o,
  output logic              last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  stq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .opcode_i      (opcode_i),
    .time_value_i  (time_value_i),
    .task_id_i     (task_id_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .fired_valid_o (fired_valid_o),
    .fired_id_o    (fired_id_o),
    .timeout_o     (timeout_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted twice in a row");

  a_pop_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> stat.due0 && cmd.emit)
    else $error("pop without a due front entry");

  a_fire_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fired_valid_o |-> !status_o && timeout_o == '0)
    else $error("fired beat carries other results");

  a_full_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> last_o)
    else $error("full status not on a last beat");

endmodule

FILE: tb/sorted_timer_queue_test.sv
`timescale 1ns / 100ps

module sorted_timer_queue_test;
  import stq_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0]   id;
    bit                drain;
    bit                hold_rx;
    bit                calm;
  } stim_t;

  typedef struct packed {
    logic              fired_valid;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] timeout;
    logic              status;
    logic              last;
  } beat_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i = '0;
  logic [TIME_W-1:0] time_value_i = '0;
  logic [ID_W-1:0]   task_id_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              fired_valid_o;
  logic [ID_W-1:0]   fired_id_o;
  logic [TIME_W-1:0] timeout_o;
  logic              status_o;
  logic              last_o;

  stim_t pending[$];
  beat_t results_due[$];
  stim_t cur;
  beat_t want;

  // predicted queue contents, front at index 0
  logic [TIME_W-1:0] due_time [DEPTH];
  logic [ID_W-1:0]   due_id   [DEPTH];
  int unsigned       task_count = 0;

  bit in_taken = 1'b0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit mark_calm = 1'b0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned fail_count = 0;
  logic [TIME_W-1:0] now_us = 63'd1000;
  logic [TIME_W-1:0] last_deadline = 63'd1000;

  sorted_timer_queue #(.DEPTH(DEPTH)) dut (.*);

  always #2 clk_i = ~clk_i;

  task automatic timer_step(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                            input logic [ID_W-1:0] id);
    int unsigned pos;
    int unsigned due;
    int unsigned j;
    beat_t b;
    b = '0;
    b.last = 1'b1;
    case (op)
      OP_INSERT: begin
        if (task_count >= DEPTH) begin
          b.status = 1'b1;
        end else begin
          pos = 0;
          while (pos < task_count && due_time[pos] < t) pos++;
          for (j = task_count; j > pos; j--) begin
            due_time[j] = due_time[j-1];
            due_id[j]   = due_id[j-1];
          end
          due_time[pos] = t;
          due_id[pos]   = id;
          task_count++;
        end
        results_due.push_back(b);
      end
      OP_ADVANCE: begin
        due = 0;
        while (due < task_count && due_time[due] < t) due++;
        if (due == 0) results_due.push_back(b);
        for (j = 0; j < due; j++) begin
          b.fired_valid = 1'b1;
          b.fired_id    = due_id[j];
          b.last        = (j + 1 == due);
          results_due.push_back(b);
        end
        for (j = due; j < task_count; j++) begin
          due_time[j-due] = due_time[j];
          due_id[j-due]   = due_id[j];
        end
        task_count -= due;
      end
      OP_QUERY: begin
        if (task_count == 0) begin
          b.timeout = EMPTY_TIMEOUT;
        end else if (due_time[0] > t) begin
          b.timeout = due_time[0] - t;
        end
        results_due.push_back(b);
      end
      default: begin
        results_due.push_back(b);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] want_v,
                             input logic [TIME_W-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  task automatic push_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] t,
                           input logic [ID_W-1:0] id, input bit hold = 1'b0,
                           input bit drain = 1'b0);
    stim_t s;
    s.op      = op;
    s.t       = t;
    s.id      = id;
    s.drain   = drain;
    s.hold_rx = hold;
    s.calm    = mark_calm;
    pending.push_back(s);
  endtask

  // inserts past capacity, a query, then flush everything
  task automatic fill_burst(input bit hold);
    push_item(OP_INSERT, now_us + TIME_W'($urandom_range(0, 400)), ID_W'($urandom), hold);
    repeat (DEPTH + 2) begin
      push_item(OP_INSERT, now_us + TIME_W'($urandom_range(0, 400)), ID_W'($urandom));
    end
    push_item(OP_QUERY, now_us, ID_W'($urandom));
    push_item(OP_ADVANCE, TIME_MAX, ID_W'($urandom));
  endtask

  task automatic push_random();
    int unsigned pick;
    logic [63:0] wide;
    logic [TIME_W-1:0] t;
    pick = $urandom_range(0, 99);
    wide = {$urandom, $urandom};
    if (pick < 48) begin
      case ($urandom_range(0, 11))
        0:       t = wide[TIME_W-1:0];
        1, 2:    t = last_deadline;
        default: t = now_us + TIME_W'($urandom_range(0, 400));
      endcase
      last_deadline = t;
      push_item(OP_INSERT, t, ID_W'($urandom));
    end else if (pick < 73) begin
      now_us = now_us + TIME_W'($urandom_range(0, 150));
      case ($urandom_range(0, 19))
        0:       t = wide[TIME_W-1:0];
        1:       t = TIME_MAX;
        default: t = now_us;
      endcase
      push_item(OP_ADVANCE, t, ID_W'($urandom));
    end else if (pick < 95) begin
      if ($urandom_range(0, 9) == 0) begin
        t = wide[TIME_W-1:0];
      end else begin
        t = now_us + TIME_W'($urandom_range(0, 300));
      end
      push_item(OP_QUERY, t, ID_W'($urandom));
    end else begin
      push_item(OP_NONE, wide[TIME_W-1:0], ID_W'($urandom));
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // beat still waiting
    end else if (send_gap != 0) begin
      send_gap--;
      in_valid_i <= 1'b0;
    end else if (pending.size() == 0) begin
      in_valid_i <= 1'b0;
    end else if (pending[0].drain) begin
      in_valid_i <= 1'b0;
      if (results_due.size() == 0) pending.delete(0);
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      send_gap = $urandom_range(0, 7);
      in_valid_i <= 1'b0;
    end else begin
      cur = pending.pop_front();
      opcode_i     <= cur.op;
      time_value_i <= cur.t;
      task_id_i    <= cur.id;
      in_valid_i   <= 1'b1;
    end
  end

  // output stall
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // accept, predict, check
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      timer_step(opcode_i, time_value_i, task_id_i);
      quiet = cur.calm;
      if (cur.hold_rx) hold_req = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat, fired_valid %b fired_id %h timeout %h status %b last %b",
                 $time, fired_valid_o, fired_id_o, timeout_o, status_o, last_o);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        check_field("fired_valid", TIME_W'(want.fired_valid), TIME_W'(fired_valid_o));
        check_field("fired_id", TIME_W'(want.fired_id), TIME_W'(fired_id_o));
        check_field("timeout", want.timeout, timeout_o);
        check_field("status", TIME_W'(want.status), TIME_W'(status_o));
        check_field("last", TIME_W'(want.last), TIME_W'(last_o));
      end
    end
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    push_item(OP_QUERY, 63'd0, 16'h0000);
    push_item(OP_ADVANCE, TIME_MAX, 16'h0000);
    push_item(OP_INSERT, 63'd0, 16'h0000);
    push_item(OP_INSERT, TIME_MAX, 16'hFFFF);
    push_item(OP_INSERT, 63'd100, 16'h0001);
    push_item(OP_INSERT, 63'd100, 16'h0002);
    push_item(OP_QUERY, 63'd0, 16'hFFFF);
    push_item(OP_ADVANCE, 63'd0, 16'h0000);
    push_item(OP_ADVANCE, 63'd1, 16'h0000);
    push_item(OP_QUERY, 63'd40, 16'h0000);
    push_item(OP_QUERY, TIME_MAX, 16'h0000);
    push_item(OP_NONE, TIME_MAX, 16'hFFFF);
    push_item(OP_ADVANCE, 63'd101, 16'h0000);
    push_item(OP_QUERY, 63'd5, 16'h0000);
    push_item(OP_ADVANCE, TIME_MAX, 16'h0000);
    push_item(OP_INSERT, TIME_MAX - 63'd1, 16'h5555);
    push_item(OP_INSERT, 63'h2AAA_AAAA_AAAA_AAAA, 16'hAAAA);
    push_item(OP_QUERY, 63'h5555_5555_5555_5555, 16'h0000);
    push_item(OP_ADVANCE, TIME_MAX, 16'hAAAA);
    push_item(OP_NONE, 63'd0, 16'h0000);

    // output held off while the input keeps offering beats
    fill_burst(1'b1);
    repeat (60) push_random();
    // sender waits for every result
    push_item(OP_NONE, '0, '0, 1'b0, 1'b1);
    repeat (60) push_random();
    fill_burst(1'b0);
    mark_calm = 1'b1;
    repeat (30) push_random();

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_valid_i || results_due.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
